// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers the reset cycles
`define BDQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and fixed constants of the button debounce event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int TIME_W      = 32;
  localparam int LEVEL_BITS  = 5;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int BTN_FIELD_W = 3;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_MASK    = 3'd4;

  localparam logic [CFG_W-1:0]      DEBOUNCE_RST   = 16'd30;
  localparam logic [CFG_W-1:0]      LONG_PRESS_RST = 16'd800;
  localparam logic [CFG_W-1:0]      REP_FIRST_RST  = 16'd400;
  localparam logic [CFG_W-1:0]      REP_PERIOD_RST = 16'd120;
  localparam logic [LEVEL_BITS-1:0] REP_MASK_RST   = 5'd15;

  localparam logic [KIND_W-1:0] KIND_PRESSED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LONG     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REPEAT   = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [BTN_FIELD_W-1:0] button;
    logic [KIND_W-1:0]      kind;
    logic [TIME_W-1:0]      stamp;
  } evt_t;

endpackage

`default_nettype wire

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/button_debounce_event_queue_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_event_queue_unit
// Debounces active-low buttons and queues press, release, long-press and
// auto-repeat events in a ring that drops its oldest entry when full.
// ----------------------------------------------------------------------------
// A sample item walks the buttons in index order through one shared 32-bit
// adder: a button that stays released passes the debounce step only, a held
// button may also pass the repeat set-up, long-press test, repeat test and
// repeat reload steps. A pop item passes a read state, which issues the
// registered read of the event RAM, and an output state that waits for the
// result register to be free. The result register lets the next item in
// while a result is still waiting. After reset every button is released.
`default_nettype none

module button_debounce_event_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_BUTTONS = 5
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [bdq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bdq_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_opcode,
  input  wire logic [bdq_pkg::TIME_W-1:0]       in_sample_time,
  input  wire logic [bdq_pkg::LEVEL_BITS-1:0]   in_raw_levels,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_event_valid,
  output logic [bdq_pkg::BTN_FIELD_W-1:0]       out_event_button,
  output logic [bdq_pkg::KIND_W-1:0]            out_event_kind,
  output logic [bdq_pkg::TIME_W-1:0]            out_event_time,
  output logic [bdq_pkg::COUNT_W-1:0]           out_queue_count,
  output logic [bdq_pkg::LEVEL_BITS-1:0]        out_stable_mask
);

  localparam int BTN_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int Q_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW     = bdq_pkg::TIME_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DEB     = 3'd1;
  localparam logic [2:0] ST_NRT     = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_REP     = 3'd4;
  localparam logic [2:0] ST_REPADD  = 3'd5;
  localparam logic [2:0] ST_POP_RD  = 3'd6;
  localparam logic [2:0] ST_POP_OUT = 3'd7;

  // configuration
  logic [bdq_pkg::CFG_W-1:0]      deb_r, lp_r, first_r, period_r;
  logic [bdq_pkg::LEVEL_BITS-1:0] rep_mask_r;

  // sequencer
  logic [2:0]                     state_r, state_nxt;
  logic [BTN_W-1:0]               btn_r, btn_nxt;
  logic [TW-1:0]                  now_r, now_nxt;
  logic [bdq_pkg::LEVEL_BITS-1:0] levels_r, levels_nxt;

  // per-button state
  logic [NUM_BUTTONS-1:0] raw_r, raw_nxt;
  logic [NUM_BUTTONS-1:0] stable_r, stable_nxt;
  logic [NUM_BUTTONS-1:0] long_r, long_nxt;
  logic [TW-1:0]          rct_r [NUM_BUTTONS];
  logic [TW-1:0]          rct_nxt [NUM_BUTTONS];
  logic [TW-1:0]          press_r [NUM_BUTTONS];
  logic [TW-1:0]          press_nxt [NUM_BUTTONS];
  logic [TW-1:0]          nrt_r [NUM_BUTTONS];
  logic [TW-1:0]          nrt_nxt [NUM_BUTTONS];

  // queue
  logic [Q_AW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              pop_hit_r, pop_hit_nxt;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_ev_r;
  logic [bdq_pkg::BTN_FIELD_W-1:0]   out_btn_r;
  logic [bdq_pkg::KIND_W-1:0]        out_kind_r;
  logic [TW-1:0]                     out_time_r;
  logic [bdq_pkg::COUNT_W-1:0]       out_count_r;
  logic [bdq_pkg::LEVEL_BITS-1:0]    out_mask_r;
  logic                              out_load;

  logic [NUM_BUTTONS-1:0]         down_all, rep_all;
  logic [bdq_pkg::LEVEL_BITS-1:0] stable_mask;

  // shared adder
  logic          alu_sub;
  logic [TW-1:0] alu_b, alu_res;

  logic                      push;
  logic [bdq_pkg::KIND_W-1:0] push_kind;
  logic                      ram_re;
  bdq_pkg::evt_t             wr_evt, rd_evt;
  logic                      full, last_btn, down, changed;

  function automatic logic [Q_AW-1:0] q_inc(input logic [Q_AW-1:0] p);
    q_inc = (p == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_btn
    if (k < bdq_pkg::LEVEL_BITS) begin : g_pin
      assign down_all[k] = ~levels_r[k];
      assign rep_all[k]  = rep_mask_r[k];
    end else begin : g_nopin
      assign down_all[k] = 1'b0;
      assign rep_all[k]  = 1'b0;
    end
  end

  for (genvar k = 0; k < bdq_pkg::LEVEL_BITS; k++) begin : g_mask
    if (k < NUM_BUTTONS) begin : g_on
      assign stable_mask[k] = stable_r[k];
    end else begin : g_off
      assign stable_mask[k] = 1'b0;
    end
  end

  assign down     = down_all[btn_r];
  assign changed  = down != raw_r[btn_r];
  assign full     = fill_r == FILL_W'(QUEUE_DEPTH);
  assign last_btn = btn_r == BTN_W'(NUM_BUTTONS - 1);
  assign in_ready = state_r == ST_IDLE;

  always_comb begin
    alu_sub = 1'b1;
    alu_b   = now_r;
    case (state_r)
      ST_DEB:    alu_b = changed ? now_r : rct_r[btn_r];
      ST_NRT:    begin alu_sub = 1'b0; alu_b = TW'(first_r); end
      ST_LONG:   alu_b = press_r[btn_r];
      ST_REP:    alu_b = nrt_r[btn_r];
      ST_REPADD: begin alu_sub = 1'b0; alu_b = TW'(period_r); end
      default:   alu_b = now_r;
    endcase
    alu_res = now_r + (alu_sub ? ~alu_b : alu_b) + TW'(alu_sub);
  end

  always_comb begin
    state_nxt   = state_r;
    btn_nxt     = btn_r;
    now_nxt     = now_r;
    levels_nxt  = levels_r;
    raw_nxt     = raw_r;
    stable_nxt  = stable_r;
    long_nxt    = long_r;
    rct_nxt     = rct_r;
    press_nxt   = press_r;
    nrt_nxt     = nrt_r;
    pop_hit_nxt = pop_hit_r;
    push        = 1'b0;
    push_kind   = bdq_pkg::KIND_PRESSED;
    ram_re      = 1'b0;
    out_load    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt    = in_sample_time;
          levels_nxt = in_raw_levels;
          btn_nxt    = '0;
          state_nxt  = (in_opcode == bdq_pkg::OP_POP) ? ST_POP_RD : ST_DEB;
        end
      end
      ST_DEB: begin
        raw_nxt[btn_r] = down;
        if (changed) begin
          rct_nxt[btn_r] = now_r;
        end
        if (down != stable_r[btn_r] && alu_res >= TW'(deb_r)) begin
          stable_nxt[btn_r] = down;
          long_nxt[btn_r]   = 1'b0;
          push              = 1'b1;
          if (down) begin
            push_kind        = bdq_pkg::KIND_PRESSED;
            press_nxt[btn_r] = now_r;
            state_nxt        = ST_NRT;
          end else begin
            push_kind        = bdq_pkg::KIND_RELEASED;
            press_nxt[btn_r] = '0;
            nrt_nxt[btn_r]   = '0;
            btn_nxt          = btn_r + 1'b1;
            state_nxt        = last_btn ? ST_IDLE : ST_DEB;
          end
        end else if (stable_r[btn_r]) begin
          state_nxt = ST_LONG;
        end else begin
          btn_nxt   = btn_r + 1'b1;
          state_nxt = last_btn ? ST_IDLE : ST_DEB;
        end
      end
      ST_NRT: begin
        nrt_nxt[btn_r] = alu_res;
        state_nxt      = ST_LONG;
      end
      ST_LONG: begin
        if (!long_r[btn_r] && alu_res >= TW'(lp_r)) begin
          long_nxt[btn_r] = 1'b1;
          push            = 1'b1;
          push_kind       = bdq_pkg::KIND_LONG;
        end
        state_nxt = ST_REP;
      end
      ST_REP: begin
        if (rep_all[btn_r] && !alu_res[TW-1]) begin
          push      = 1'b1;
          push_kind = bdq_pkg::KIND_REPEAT;
          state_nxt = ST_REPADD;
        end else begin
          btn_nxt   = btn_r + 1'b1;
          state_nxt = last_btn ? ST_IDLE : ST_DEB;
        end
      end
      ST_REPADD: begin
        nrt_nxt[btn_r] = alu_res;
        btn_nxt        = btn_r + 1'b1;
        state_nxt      = last_btn ? ST_IDLE : ST_DEB;
      end
      ST_POP_RD: begin
        pop_hit_nxt = fill_r != '0;
        ram_re      = fill_r != '0;
        state_nxt   = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = q_inc(tail_r);
      if (full) begin
        head_nxt = q_inc(head_r);
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end else if (ram_re) begin
      head_nxt = q_inc(head_r);
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign wr_evt.button = bdq_pkg::BTN_FIELD_W'(btn_r);
  assign wr_evt.kind   = push_kind;
  assign wr_evt.stamp  = now_r;

  bdq_ram #(
    .WIDTH ($bits(bdq_pkg::evt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata (wr_evt),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (rd_evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= bdq_pkg::DEBOUNCE_RST;
      lp_r        <= bdq_pkg::LONG_PRESS_RST;
      first_r     <= bdq_pkg::REP_FIRST_RST;
      period_r    <= bdq_pkg::REP_PERIOD_RST;
      rep_mask_r  <= bdq_pkg::REP_MASK_RST;
      state_r     <= ST_IDLE;
      btn_r       <= '0;
      raw_r       <= '0;
      stable_r    <= '0;
      long_r      <= '0;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        rct_r[k]   <= '0;
        press_r[k] <= '0;
        nrt_r[k]   <= '0;
      end
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      pop_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bdq_pkg::CFG_DEBOUNCE:   deb_r      <= cfg_wdata;
          bdq_pkg::CFG_LONG_PRESS: lp_r       <= cfg_wdata;
          bdq_pkg::CFG_REP_FIRST:  first_r    <= cfg_wdata;
          bdq_pkg::CFG_REP_PERIOD: period_r   <= cfg_wdata;
          bdq_pkg::CFG_REP_MASK:   rep_mask_r <= cfg_wdata[bdq_pkg::LEVEL_BITS-1:0];
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      btn_r       <= btn_nxt;
      raw_r       <= raw_nxt;
      stable_r    <= stable_nxt;
      long_r      <= long_nxt;
      rct_r       <= rct_nxt;
      press_r     <= press_nxt;
      nrt_r       <= nrt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      pop_hit_r   <= pop_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    levels_r <= levels_nxt;
    if (out_load) begin
      out_ev_r    <= pop_hit_r;
      out_btn_r   <= pop_hit_r ? rd_evt.button : '0;
      out_kind_r  <= pop_hit_r ? rd_evt.kind : '0;
      out_time_r  <= pop_hit_r ? rd_evt.stamp : '0;
      out_count_r <= bdq_pkg::COUNT_W'(fill_r);
      out_mask_r  <= stable_mask;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_valid  = out_ev_r;
  assign out_event_button = out_btn_r;
  assign out_event_kind   = out_kind_r;
  assign out_event_time   = out_time_r;
  assign out_queue_count  = out_count_r;
  assign out_stable_mask  = out_mask_r;

endmodule

`default_nettype wire

// File: rtl/bdq_chk.sv
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks on the button debounce event queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bdq_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             in_opcode,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_event_valid,
  input wire logic [bdq_pkg::BTN_FIELD_W-1:0]  out_event_button,
  input wire logic [bdq_pkg::KIND_W-1:0]       out_event_kind,
  input wire logic [bdq_pkg::TIME_W-1:0]       out_event_time,
  input wire logic [bdq_pkg::COUNT_W-1:0]      out_queue_count
);

  `BDQ_ASSERT_RST(a_rst_no_result, clk, !rst_n |=> !out_valid, "result shown after reset")

  `BDQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

  `BDQ_ASSERT(a_sample_silent, clk, rst_n, in_valid && in_ready && in_opcode == bdq_pkg::OP_SAMPLE && !out_valid |=> !out_valid, "sample item gave a result")

  `BDQ_ASSERT(a_empty_pop, clk, rst_n, out_valid && !out_event_valid |-> out_event_button == '0 && out_event_kind == '0 && out_event_time == '0 && out_queue_count == '0, "empty pop fields not zero")

  `BDQ_ASSERT(a_button_range, clk, rst_n, out_valid && out_event_valid |-> out_event_button <= 3'd4, "event from a button without a pin")

endmodule

bind button_debounce_event_queue_unit bdq_chk u_bdq_chk (.*);

`default_nettype wire
